@@ src/random_led_digit_pattern_engine_defines.svh @@
// Assertion macros for the LED digit pattern engine.
// Each macro expects clk_i and rst_ni in scope.
`ifndef RANDOM_LED_DIGIT_PATTERN_ENGINE_DEFINES_SVH
`define RANDOM_LED_DIGIT_PATTERN_ENGINE_DEFINES_SVH
`ifndef SYNTH
`define RLDP_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rldp: implication check failed");
`define RLDP_ASSERT_NEVER(name, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("rldp: forbidden condition seen");
`else
`define RLDP_ASSERT_IMPL(name, ante, cons)
`define RLDP_ASSERT_NEVER(name, expr)
`endif
`endif

@@ src/rldp_pkg.sv @@
package rldp_pkg;

  localparam int unsigned CELLS = 27;
  localparam logic [63:0] RLDP_TAPS = 64'h0000_0000_8020_0003;

  typedef enum logic [1:0] {
    CMD_SET   = 2'd0,
    CMD_ALIGN = 2'd1,
    CMD_SWAP  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OFF   = 2'd0,
    ST_ON    = 2'd1,
    ST_START = 2'd2,
    ST_STOP  = 2'd3
  } cell_e;

  typedef enum logic [1:0] {
    SW_OK    = 2'd0,
    SW_ALIKE = 2'd1,
    SW_NOOFF = 2'd2,
    SW_NONE  = 2'd3
  } swap_res_e;

  typedef enum logic [2:0] {
    PR_WANT0,
    PR_WANT1,
    PR_MIS,
    PR_ON,
    PR_OFF
  } pred_e;

  typedef enum logic [2:0] {
    AC_SETW1,
    AC_SETW0,
    AC_ALIGN,
    AC_SWON,
    AC_SWOFF
  } act_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEL,
    S_SELW,
    S_GROUP,
    S_SCAN,
    S_CHK,
    S_DRAW,
    S_WAIT,
    S_RDK,
    S_RDL,
    S_NEXT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic       start;
    logic [3:0] n;
  } draw_req_t;

  typedef struct packed {
    logic       done;
    logic [3:0] value;
  } draw_rsp_t;

  function automatic logic [4:0] grp_base(input logic [1:0] g);
    logic [4:0] b;
    case (g)
      2'd0:    b = 5'd0;
      2'd1:    b = 5'd3;
      2'd2:    b = 5'd12;
      default: b = 5'd18;
    endcase
    return b;
  endfunction

  function automatic logic [3:0] grp_size(input logic [1:0] g);
    logic [3:0] s;
    case (g)
      2'd0:    s = 4'd3;
      2'd1:    s = 4'd9;
      2'd2:    s = 4'd6;
      default: s = 4'd9;
    endcase
    return s;
  endfunction

  function automatic logic [CELLS-1:0] grp_mask(input logic [1:0] g);
    logic [CELLS-1:0] m;
    case (g)
      2'd0:    m = 27'h000_0007;
      2'd1:    m = 27'h000_0FF8;
      2'd2:    m = 27'h003_F000;
      default: m = 27'h7FC_0000;
    endcase
    return m;
  endfunction

endpackage

@@ src/rldp_in_if.sv @@
interface rldp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [4:0] hour;
  logic [5:0] minute;

  modport source (output valid, command, hour, minute, input ready);
  modport sink (input valid, command, hour, minute, output ready);
endinterface

@@ src/rldp_out_if.sv @@
interface rldp_out_if;
  logic        valid;
  logic        ready;
  logic [53:0] source_cells;
  logic [26:0] wanted_cells;
  logic [1:0]  swap_result;

  modport source (output valid, source_cells, wanted_cells, swap_result, input ready);
  modport sink (input valid, source_cells, wanted_cells, swap_result, output ready);
endinterface

@@ src/rldp_draw.sv @@
module rldp_draw #(
  parameter int unsigned LFSR_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               seed_we_i,
  input  logic [31:0]        seed_i,
  input  rldp_pkg::draw_req_t req_i,
  output rldp_pkg::draw_rsp_t rsp_o
);
  import rldp_pkg::*;

  localparam int unsigned CW = $clog2(LFSR_WIDTH + 1);
  localparam logic [LFSR_WIDTH-1:0] TAPS = LFSR_WIDTH'(RLDP_TAPS);

  logic [LFSR_WIDTH-1:0] lfsr_q, sh_q, step, seed_v;
  logic [3:0]            n_q, rem_q, rem_d;
  logic [CW-1:0]         cnt_q;
  logic                  busy_q;
  logic [4:0]            trial;

  always_comb begin
    step = (lfsr_q >> 1) ^ (lfsr_q[0] ? TAPS : '0);
    if (step == '0) begin
      step = LFSR_WIDTH'(1);
    end
    seed_v = LFSR_WIDTH'({32'd0, seed_i});
    if (seed_v == '0) begin
      seed_v = LFSR_WIDTH'(1);
    end
  end

  // One remainder bit per cycle, MSB first; rem < n <= 9 keeps one subtract enough.
  assign trial = {rem_q, sh_q[LFSR_WIDTH-1]};
  assign rem_d = (trial >= {1'b0, n_q}) ? 4'(trial - {1'b0, n_q}) : trial[3:0];

  assign rsp_o.done  = busy_q && (cnt_q == '0);
  assign rsp_o.value = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q <= LFSR_WIDTH'(1);
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (seed_we_i) begin
      lfsr_q <= seed_v;
    end else if (req_i.start) begin
      lfsr_q <= step;
      busy_q <= 1'b1;
      cnt_q  <= CW'(LFSR_WIDTH);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      sh_q  <= step;
      n_q   <= req_i.n;
      rem_q <= '0;
    end else if (busy_q && cnt_q != '0) begin
      sh_q  <= sh_q << 1;
      rem_q <= rem_d;
    end
  end

endmodule

@@ src/random_led_digit_pattern_engine.sv @@
// LED digit pattern engine for a 27-cell clock face (groups of 3, 9, 6, 9 cells).
// Requests arrive on req_i (valid/ready); each carries command, hour, minute.
// Every request gives exactly one result on rsp_o (valid/ready): all cell
// states, the wanted pattern and the swap outcome.
// req_i.ready is high only while the sequencer is idle; one request is worked
// at a time. A random draw runs in the shared draw unit, one remainder bit per
// cycle. A group walk scans its cells in turn to list its candidates, then
// draws once for each cell changed. Align: one draw per group with a mismatched
// cell; swap: one draw to pick the group (a draw of 4 or 5 ends the request),
// then two walks with one draw each; set: up to 8 picks per group. The draw
// unit's serial remainder sets the rate.
// A finished result sits in the output register, so the next request is taken
// while it waits; a further result waits in the done state while the
// receiver stalls.
// Reset: all cells off, wanted pattern zero, generator loaded with seed 1.
// cfg_we_i loads cfg_wdata_i as seed at once (zero within the width loads 1).
`include "random_led_digit_pattern_engine_defines.svh"

module random_led_digit_pattern_engine #(
  parameter int unsigned LFSR_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  rldp_in_if.sink     req_i,
  rldp_out_if.source  rsp_o
);
  import rldp_pkg::*;

  state_e            state_q, state_d;
  cmd_e              cmd_q;
  logic [3:0][3:0]   dig_q;
  logic [1:0]        grp_q;
  logic              pass_q;
  pred_e             pred_q, plan_pred;
  act_e              act_q, plan_act;
  logic [3:0]        picks_q, plan_picks;
  logic [3:0]        idx_q, list_n_q, k_q;
  swap_res_e         res_q, plan_res;
  logic              plan_scan, plan_done, plan_fill;

  logic [CELLS-1:0][1:0] st_q;
  logic [CELLS-1:0]      want_q;

  logic [53:0]       out_src_q;
  logic [26:0]       out_want_q;
  swap_res_e         out_res_q;
  logic              out_valid_q;

  logic [3:0]        list_mem [9];
  logic [3:0]        rd_q, rd_addr;
  logic              mem_we;
  logic [3:0]        mem_waddr, mem_wdata;

  draw_req_t         draw_req;
  draw_rsp_t         draw_rsp;

  logic [4:0]        base, sc, cell_idx;
  logic [3:0]        size, dig, cnt_want, cnt_on, cnt_off;
  logic [CELLS-1:0]  gmask;
  logic              hit, accept, out_free;
  logic [7:0]        hsplit, msplit;

  // Split a value below 64 into tens and units.
  function automatic logic [7:0] split10(input logic [5:0] v);
    logic [3:0] t;
    logic [5:0] u;
    t = 4'd0;
    for (int i = 1; i <= 6; i++) begin
      if (v >= 6'(i * 10)) begin
        t = 4'(i);
      end
    end
    u = v - 6'(t) * 6'd10;
    return {t, u[3:0]};
  endfunction

  function automatic logic [3:0] count_set(input logic [CELLS-1:0] m);
    logic [3:0] c;
    c = 4'd0;
    for (int i = 0; i < CELLS; i++) begin
      c = c + 4'(m[i]);
    end
    return c;
  endfunction

  rldp_draw #(.LFSR_WIDTH(LFSR_WIDTH)) u_draw (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .seed_we_i (cfg_we_i),
    .seed_i    (cfg_wdata_i),
    .req_i     (draw_req),
    .rsp_o     (draw_rsp)
  );

  always_comb begin
    logic [CELLS-1:0] on_m, off_m;
    base  = grp_base(grp_q);
    size  = grp_size(grp_q);
    gmask = grp_mask(grp_q);
    dig   = dig_q[grp_q];
    for (int i = 0; i < CELLS; i++) begin
      on_m[i]  = (st_q[i] == ST_ON);
      off_m[i] = (st_q[i] == ST_OFF);
    end
    cnt_want = count_set(want_q & gmask);
    cnt_on   = count_set(on_m & gmask);
    cnt_off  = count_set(off_m & gmask);
    sc       = base + 5'(idx_q);
    cell_idx = base + 5'(rd_q);
    hsplit   = split10({1'b0, req_i.hour});
    msplit   = split10(req_i.minute);
  end

  // Candidate test for the cell under the scan pointer.
  always_comb begin
    case (pred_q)
      PR_WANT0: hit = !want_q[sc];
      PR_WANT1: hit = want_q[sc];
      PR_MIS:   hit = want_q[sc] ? !(st_q[sc] == ST_ON || st_q[sc] == ST_START)
                                 : !(st_q[sc] == ST_OFF || st_q[sc] == ST_STOP);
      PR_ON:    hit = (st_q[sc] == ST_ON);
      PR_OFF:   hit = (st_q[sc] == ST_OFF);
      default:  hit = 1'b0;
    endcase
  end

  // Decide what the current group needs.
  always_comb begin
    plan_scan  = 1'b0;
    plan_done  = 1'b0;
    plan_fill  = 1'b0;
    plan_pred  = PR_WANT0;
    plan_act   = AC_SETW1;
    plan_picks = 4'd1;
    plan_res   = SW_NONE;
    case (cmd_q)
      CMD_SET: begin
        if (dig == 4'd0 || dig >= size) begin
          plan_fill = 1'b1;
        end else if (cnt_want < dig) begin
          plan_scan  = 1'b1;
          plan_picks = dig - cnt_want;
        end else if (cnt_want > dig) begin
          plan_scan  = 1'b1;
          plan_pred  = PR_WANT1;
          plan_act   = AC_SETW0;
          plan_picks = cnt_want - dig;
        end
      end
      CMD_ALIGN: begin
        plan_scan = 1'b1;
        plan_pred = PR_MIS;
        plan_act  = AC_ALIGN;
      end
      CMD_SWAP: begin
        if (pass_q) begin
          plan_scan = 1'b1;
          plan_pred = PR_OFF;
          plan_act  = AC_SWOFF;
        end else if (cnt_on == 4'd0 || cnt_on == size) begin
          plan_done = 1'b1;
          plan_res  = SW_ALIKE;
        end else if (cnt_off == 4'd0) begin
          plan_done = 1'b1;
          plan_res  = SW_NOOFF;
        end else begin
          plan_scan = 1'b1;
          plan_pred = PR_ON;
          plan_act  = AC_SWON;
        end
      end
      default: plan_done = 1'b1;
    endcase
  end

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          case (cmd_e'(req_i.command))
            CMD_SET, CMD_ALIGN: state_d = S_GROUP;
            CMD_SWAP:           state_d = S_SEL;
            default:            state_d = S_DONE;
          endcase
        end
      end
      S_SEL:   state_d = S_SELW;
      S_SELW: begin
        if (draw_rsp.done) begin
          state_d = (draw_rsp.value < 4'd4) ? S_GROUP : S_DONE;
        end
      end
      S_GROUP: begin
        if (plan_scan) begin
          state_d = S_SCAN;
        end else if (plan_done) begin
          state_d = S_DONE;
        end else begin
          state_d = S_NEXT;
        end
      end
      S_SCAN: begin
        if (idx_q == size - 4'd1) begin
          state_d = S_CHK;
        end
      end
      S_CHK:   state_d = (list_n_q == 4'd0) ? S_NEXT : S_DRAW;
      S_DRAW:  state_d = S_WAIT;
      S_WAIT: begin
        if (draw_rsp.done) begin
          state_d = S_RDK;
        end
      end
      S_RDK:   state_d = S_RDL;
      S_RDL:   state_d = (picks_q == 4'd1) ? S_NEXT : S_DRAW;
      S_NEXT: begin
        if (cmd_q == CMD_SWAP) begin
          state_d = pass_q ? S_DONE : S_GROUP;
        end else begin
          state_d = (grp_q == 2'd3) ? S_DONE : S_GROUP;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    req_i.ready    = (state_q == S_IDLE);
    draw_req.start = 1'b0;
    draw_req.n     = list_n_q;
    mem_we         = 1'b0;
    mem_waddr      = list_n_q;
    mem_wdata      = idx_q;
    rd_addr        = k_q;
    case (state_q)
      S_SEL: begin
        draw_req.start = 1'b1;
        draw_req.n     = 4'd6;
      end
      S_DRAW: draw_req.start = 1'b1;
      S_SCAN: mem_we = hit;
      S_WAIT: rd_addr = draw_rsp.value;
      S_RDK:  rd_addr = list_n_q - 4'd1;
      S_RDL: begin
        mem_we    = 1'b1;
        mem_waddr = k_q;
        mem_wdata = rd_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      list_mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= (rd_addr < 4'd9) ? list_mem[rd_addr] : 4'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      st_q        <= '0;
      want_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // Load a finished result, else drop valid once the receiver takes it.
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_GROUP: begin
          if (plan_fill) begin
            for (int i = 0; i < CELLS; i++) begin
              if (gmask[i]) begin
                want_q[i] <= (dig != 4'd0);
              end
            end
          end
        end
        S_RDK: begin
          case (act_q)
            AC_SETW1: want_q[cell_idx] <= 1'b1;
            AC_SETW0: want_q[cell_idx] <= 1'b0;
            AC_ALIGN: st_q[cell_idx] <= want_q[cell_idx] ? ST_START : ST_STOP;
            AC_SWON: begin
              st_q[cell_idx]   <= ST_STOP;
              want_q[cell_idx] <= 1'b0;
            end
            AC_SWOFF: begin
              st_q[cell_idx]   <= ST_START;
              want_q[cell_idx] <= 1'b1;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Working registers of the sequencer.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_q  <= cmd_e'(req_i.command);
          dig_q  <= {msplit[3:0], msplit[7:4], hsplit[3:0], hsplit[7:4]};
          grp_q  <= 2'd0;
          pass_q <= 1'b0;
          res_q  <= SW_NONE;
        end
      end
      S_SELW: begin
        if (draw_rsp.done) begin
          grp_q <= draw_rsp.value[1:0];
        end
      end
      S_GROUP: begin
        pred_q   <= plan_pred;
        act_q    <= plan_act;
        picks_q  <= plan_picks;
        idx_q    <= 4'd0;
        list_n_q <= 4'd0;
        if (plan_done) begin
          res_q <= plan_res;
        end
      end
      S_SCAN: begin
        idx_q <= idx_q + 4'd1;
        if (hit) begin
          list_n_q <= list_n_q + 4'd1;
        end
      end
      S_WAIT: begin
        if (draw_rsp.done) begin
          k_q <= draw_rsp.value;
        end
      end
      S_RDL: begin
        list_n_q <= list_n_q - 4'd1;
        picks_q  <= picks_q - 4'd1;
      end
      S_NEXT: begin
        if (cmd_q == CMD_SWAP) begin
          pass_q <= 1'b1;
          if (pass_q) begin
            res_q <= SW_OK;
          end
        end else begin
          grp_q <= grp_q + 2'd1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_src_q  <= st_q;
          out_want_q <= want_q;
          out_res_q  <= res_q;
        end
      end
      default: ;
    endcase
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.source_cells = out_src_q;
  assign rsp_o.wanted_cells = out_want_q;
  assign rsp_o.swap_result  = out_res_q;

  `RLDP_ASSERT_IMPL(a_list_bound, state_q == S_CHK, list_n_q <= 4'd9)
  `RLDP_ASSERT_IMPL(a_draw_wait, draw_rsp.done, state_q == S_WAIT || state_q == S_SELW)
  `RLDP_ASSERT_IMPL(a_cell_range, state_q == S_RDK, cell_idx < 5'd27)

endmodule
